### hw/rtl/hka_pkg.sv
// Shared types, constants and the response curve table of the Hall key actuation block.
// Depends on nothing; every other file imports it.
package hka_pkg;

	localparam int KEY_COUNT    = 128;
	localparam int KEY_BITS     = 7;
	localparam int SAMPLE_BITS  = 12;
	localparam int CURVE_COUNT  = 5;
	localparam int CURVE_POINTS = 101;
	localparam int ROM_DEPTH    = CURVE_COUNT * CURVE_POINTS;
	localparam int ROM_IDX_BITS = $clog2(ROM_DEPTH);
	localparam int FIFO_DEPTH   = 4;
	localparam int FIFO_PTR     = $clog2(FIFO_DEPTH);
	localparam int NUM_BITS     = SAMPLE_BITS + 7;

	localparam logic [6:0] FULL_TRAVEL = 7'd100;

	// Register indexes of the configuration port
	localparam logic [2:0] REG_RAPID_ON   = 3'd0;
	localparam logic [2:0] REG_CALIB_ON   = 3'd1;
	localparam logic [2:0] REG_REL_MARGIN = 3'd2;
	localparam logic [2:0] REG_RAP_MARGIN = 3'd3;
	localparam logic [2:0] REG_THR_MARGIN = 3'd4;
	localparam logic [2:0] REG_MIN_RANGE  = 3'd5;

	// Item kinds
	localparam logic KIND_SAMPLE = 1'b0;
	localparam logic KIND_LOAD   = 1'b1;

	typedef struct packed {
		logic        rapid_on;
		logic        calib_on;
		logic [6:0]  release_margin;
		logic [6:0]  rapid_margin;
		logic [5:0]  threshold_margin;
		logic [11:0] min_range;
	} cfg_t;

	typedef struct packed {
		logic                   kind;
		logic [KEY_BITS-1:0]    key;
		logic [SAMPLE_BITS-1:0] sample;
		logic [11:0]            base;
		logic [11:0]            range;
		logic [6:0]             thr;
		logic [2:0]             curve;
	} item_t;

	typedef struct packed {
		logic [11:0] base;
		logic [11:0] range;
		logic [6:0]  thr;
		logic [2:0]  curve;
	} key_cfg_t;

	typedef struct packed {
		logic       pressed;
		logic [6:0] extreme;
	} key_state_t;

	typedef struct packed {
		logic [KEY_BITS-1:0] key;
		logic                pressed;
		logic                changed;
		logic [6:0]          level;
		logic [11:0]         range;
	} result_t;

	typedef struct packed {
		logic empty;
		logic full;
	} fifo_status_t;

	typedef struct packed {
		logic busy;
		logic pop;
	} back_status_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_PREP,
		BK_DIV,
		BK_LOOK,
		BK_FIN
	} back_state_t;

	typedef logic [6:0] curve_rom_t [ROM_DEPTH];

	// Largest k in 0..100 with a*k*k + b*k <= c*x
	function automatic logic [6:0] curve_point(int a, int b, int c, int x);
		int k;
		k = 0;
		while (k < 100 && a * (k + 1) * (k + 1) + b * (k + 1) <= c * x)
			k++;
		return k[6:0];
	endfunction

	// Build the five curves: linear, three gentle bends, square root
	function automatic curve_rom_t build_curves();
		curve_rom_t rom;
		for (int x = 0; x < CURVE_POINTS; x++) begin
			rom[x]                    = x[6:0];
			rom[CURVE_POINTS + x]     = curve_point(3, 700, 1000, x);
			rom[2 * CURVE_POINTS + x] = curve_point(3, 200, 500, x);
			rom[3 * CURVE_POINTS + x] = curve_point(17, 300, 2000, x);
			rom[4 * CURVE_POINTS + x] = curve_point(1, 0, 100, x);
		end
		return rom;
	endfunction

	localparam curve_rom_t CURVE_ROM = build_curves();

endpackage

### hw/rtl/hka_front.sv
// Front end: accepts stream requests and normalizes load fields before queueing.
// Depends on hka_pkg.
module hka_front import hka_pkg::*; (
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [55:0]            s_axis_tdata,
	input  logic                   s_axis_tuser,
	input  cfg_t                   cfg,
	input  fifo_status_t           fifo_st,
	output logic                   push,
	output item_t                  push_item
);

	logic [11:0] rng_in;
	logic [2:0]  cur_in;

	// Accept while the queue has room
	assign s_axis_tready = !fifo_st.full;
	assign push          = s_axis_tvalid && !fifo_st.full;

	assign rng_in = s_axis_tdata[42:31];
	assign cur_in = s_axis_tdata[52:50];

	// Unpack and clamp range up to min_range, unknown curves to linear
	always_comb begin
		push_item.kind   = s_axis_tuser;
		push_item.key    = s_axis_tdata[6:0];
		push_item.sample = s_axis_tdata[18:7];
		push_item.base   = s_axis_tdata[30:19];
		push_item.range  = (rng_in < cfg.min_range) ? cfg.min_range : rng_in;
		push_item.thr    = s_axis_tdata[49:43];
		push_item.curve  = (32'(cur_in) >= CURVE_COUNT) ? 3'd0 : cur_in;
	end

endmodule

### hw/rtl/hka_fifo.sv
// Short request queue between the front end and the back end.
// Depends on hka_pkg.
module hka_fifo import hka_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  item_t        push_item,
	input  logic         pop,
	output item_t        head_item,
	output fifo_status_t status
);

	item_t                mem_q [FIFO_DEPTH];
	logic [FIFO_PTR-1:0]  wr_q;
	logic [FIFO_PTR-1:0]  rd_q;
	logic [FIFO_PTR:0]    cnt_q;

	assign head_item    = mem_q[rd_q];
	assign status.empty = (cnt_q == '0);
	assign status.full  = (cnt_q == (FIFO_PTR + 1)'(FIFO_DEPTH));

	// Store entries
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= push_item;
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + 1'b1;
			if (pop)
				rd_q <= rd_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### hw/rtl/hka_back.sv
// Back end: per-key memories, travel divider, curve lookup, press decision, result register.
// Depends on hka_pkg.
module hka_back import hka_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  cfg_t         cfg,
	input  fifo_status_t fifo_st,
	input  item_t        head_item,
	output logic         pop,
	output back_status_t status,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output result_t      result
);

	key_cfg_t    kcfg_mem [KEY_COUNT];
	key_state_t  kst_mem  [KEY_COUNT];
	logic [KEY_COUNT-1:0] vld_q;

	back_state_t state_q, state_d;
	item_t       itm_q;
	key_cfg_t    kc_q;
	key_state_t  ks_rd_q;
	logic        ks_vld_q;
	logic [12:0] diff_q;
	logic [NUM_BITS-1:0] rem_q;
	logic [NUM_BITS-1:0] dsh_q;
	logic [2:0]  cnt_q;
	logic [6:0]  pct_q;
	logic [6:0]  lvl_q;
	logic        out_vld_q;
	result_t     out_q;

	key_state_t  ks;
	logic [12:0] diff;
	logic [11:0] divisor;
	logic        div_ge;
	logic        out_free;
	logic [2:0]  rom_cur;
	logic [6:0]  rom_x;
	logic [ROM_IDX_BITS-1:0] rom_idx;
	logic        kcfg_we;
	key_cfg_t    kcfg_wd;
	logic        kst_we;
	key_state_t  kst_wd;
	logic        chg;
	logic [6:0]  thr_ld;

	assign ks       = ks_vld_q ? ks_rd_q : '0;
	assign diff     = (itm_q.sample < kc_q.base) ? 13'(kc_q.base) - 13'(itm_q.sample)
	                                             : 13'(itm_q.sample) - 13'(kc_q.base);
	assign divisor  = (kc_q.range == '0) ? 12'd1 : kc_q.range;
	assign div_ge   = (rem_q >= dsh_q);
	assign out_free = !out_vld_q || m_axis_tready;

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: if (!fifo_st.empty) state_d = BK_PREP;
			BK_PREP: begin
				if (itm_q.kind == KIND_LOAD || diff >= 13'(divisor))
					state_d = BK_LOOK;
				else
					state_d = BK_DIV;
			end
			BK_DIV:  if (cnt_q == '0) state_d = BK_LOOK;
			BK_LOOK: state_d = BK_FIN;
			BK_FIN:  if (out_free) state_d = BK_IDLE;
			default: state_d = BK_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		pop = (state_q == BK_IDLE) && !fifo_st.empty;
		status.busy = (state_q != BK_IDLE);
		status.pop  = pop;
	end

	// Curve table address: load floor or sample travel
	always_comb begin
		if (itm_q.kind == KIND_LOAD) begin
			rom_cur = itm_q.curve;
			rom_x   = 7'(cfg.threshold_margin);
		end else begin
			rom_cur = (32'(kc_q.curve) >= CURVE_COUNT) ? 3'd0 : kc_q.curve;
			rom_x   = pct_q;
		end
		rom_idx = ROM_IDX_BITS'(10'(rom_cur) * 10'(CURVE_POINTS) + 10'(rom_x));
	end

	// Press decision and write-back data
	always_comb begin
		chg     = 1'b0;
		kst_wd  = ks;
		thr_ld  = (itm_q.thr < lvl_q) ? lvl_q : itm_q.thr;
		kcfg_wd = kc_q;
		if (ks.pressed) begin
			if (cfg.rapid_on) begin
				if (8'(lvl_q) + 8'(cfg.rapid_margin) < 8'(ks.extreme)) begin
					kst_wd.pressed = 1'b0;
					kst_wd.extreme = lvl_q;
					chg = 1'b1;
				end else if (lvl_q > ks.extreme) begin
					kst_wd.extreme = lvl_q;
				end
			end else if (8'(lvl_q) + 8'(cfg.release_margin) < 8'(kc_q.thr)) begin
				kst_wd.pressed = 1'b0;
				chg = 1'b1;
			end
		end else begin
			if (cfg.rapid_on) begin
				if (lvl_q > kc_q.thr &&
				    8'(lvl_q) > 8'(ks.extreme) + 8'(cfg.rapid_margin)) begin
					kst_wd.pressed = 1'b1;
					kst_wd.extreme = lvl_q;
					chg = 1'b1;
				end else if (lvl_q < ks.extreme) begin
					kst_wd.extreme = lvl_q;
				end
			end else if (lvl_q > kc_q.thr) begin
				kst_wd.pressed = 1'b1;
				chg = 1'b1;
			end
		end
		if (itm_q.kind == KIND_LOAD) begin
			kcfg_wd.base  = itm_q.base;
			kcfg_wd.range = itm_q.range;
			kcfg_wd.thr   = thr_ld;
			kcfg_wd.curve = itm_q.curve;
		end else if (cfg.calib_on && diff_q > 13'(kc_q.range)) begin
			kcfg_wd.range = diff_q[11:0];
		end
		kcfg_we = (state_q == BK_FIN) && out_free &&
		          (itm_q.kind == KIND_LOAD || (cfg.calib_on && diff_q > 13'(kc_q.range)));
		kst_we  = (state_q == BK_FIN) && out_free && (itm_q.kind == KIND_SAMPLE);
	end

	// Key memories: read on pop, write at finish
	always_ff @(posedge clk) begin
		if (pop) begin
			kc_q    <= kcfg_mem[head_item.key];
			ks_rd_q <= kst_mem[head_item.key];
		end
		if (kcfg_we)
			kcfg_mem[itm_q.key] <= kcfg_wd;
		if (kst_we)
			kst_mem[itm_q.key] <= kst_wd;
	end

	// Datapath registers: item, divider, curve level
	always_ff @(posedge clk) begin
		if (pop)
			itm_q <= head_item;
		case (state_q)
			BK_PREP: begin
				diff_q <= diff;
				pct_q  <= (diff >= 13'(divisor)) ? FULL_TRAVEL : 7'd0;
				rem_q  <= NUM_BITS'(diff[11:0]) * NUM_BITS'(100);
				dsh_q  <= NUM_BITS'(divisor) << 6;
				cnt_q  <= 3'd6;
			end
			BK_DIV: begin
				if (div_ge)
					rem_q <= rem_q - dsh_q;
				dsh_q <= dsh_q >> 1;
				pct_q <= {pct_q[5:0], div_ge};
				cnt_q <= cnt_q - 1'b1;
			end
			BK_LOOK: lvl_q <= CURVE_ROM[rom_idx];
			default: ;
		endcase
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (state_q == BK_FIN && out_free) begin
			out_q.key <= itm_q.key;
			if (itm_q.kind == KIND_LOAD) begin
				out_q.pressed <= ks.pressed;
				out_q.changed <= 1'b0;
				out_q.level   <= 7'd0;
			end else begin
				out_q.pressed <= kst_wd.pressed;
				out_q.changed <= chg;
				out_q.level   <= lvl_q;
			end
			out_q.range <= kcfg_wd.range;
		end
	end

	// Control: state, valid bits, result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= BK_IDLE;
			vld_q     <= '0;
			ks_vld_q  <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop)
				ks_vld_q <= vld_q[head_item.key];
			if (kst_we)
				vld_q[itm_q.key] <= 1'b1;
			if (state_q == BK_FIN && out_free)
				out_vld_q <= 1'b1;
			else if (m_axis_tready)
				out_vld_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign result        = out_q;

endmodule

### hw/rtl/hall_key_actuation.sv
// Top level of the Hall key actuation block: configuration registers, front, queue, back.
// Depends on hka_pkg, hka_front, hka_fifo and hka_back.

// Each request (a key load or a sensor sample) yields one result. A load or a sample at or past
// full travel goes from the idle state through the prepare, lookup and finish states; a sample
// inside the travel also passes the divide state, the 7-step restoring divider that turns the
// sensor difference into percent. Finish waits while the result register is still full, and the
// back end takes no new request until its result is registered. The 4-entry queue lets new
// requests in while one is worked on and a result waits. Per-key pressed state and tracked
// extreme clear at reset; a key's calibration must be loaded before it is sampled.
module hall_key_actuation import hka_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [11:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// key_index[6:0], sensor_sample[18:7], base_value[30:19], range_value[42:31],
	// threshold_value[49:43], curve_select[52:50], zero[55:53]
	input  logic [55:0] s_axis_tdata,
	// kind[0]
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// key_out[6:0], pressed[7], changed[8], travel_level[15:9], range_now[27:16], zero[31:28]
	output logic [31:0] m_axis_tdata
);

	cfg_t         cfg_q;
	fifo_status_t fifo_st;
	back_status_t bk_st;
	item_t        push_item;
	item_t        head_item;
	logic         push;
	logic         pop;
	result_t      result;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rapid_on         <= 1'b0;
			cfg_q.calib_on         <= 1'b0;
			cfg_q.release_margin   <= 7'd5;
			cfg_q.rapid_margin     <= 7'd5;
			cfg_q.threshold_margin <= 6'd5;
			cfg_q.min_range        <= 12'd100;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RAPID_ON:   cfg_q.rapid_on         <= cfg_wdata[0];
				REG_CALIB_ON:   cfg_q.calib_on         <= cfg_wdata[0];
				REG_REL_MARGIN: cfg_q.release_margin   <= cfg_wdata[6:0];
				REG_RAP_MARGIN: cfg_q.rapid_margin     <= cfg_wdata[6:0];
				REG_THR_MARGIN: cfg_q.threshold_margin <= cfg_wdata[5:0];
				REG_MIN_RANGE:  cfg_q.min_range        <= cfg_wdata;
				default: ;
			endcase
		end
	end

	hka_front u_front (
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.cfg           (cfg_q),
		.fifo_st       (fifo_st),
		.push          (push),
		.push_item     (push_item)
	);

	hka_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head_item (head_item),
		.status    (fifo_st)
	);

	hka_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.fifo_st       (fifo_st),
		.head_item     (head_item),
		.pop           (pop),
		.status        (bk_st),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.result        (result)
	);

	// Pack the result
	assign m_axis_tdata = {4'd0, result.range, result.level, result.changed,
	                       result.pressed, result.key};

`ifndef SYNTHESIS
	// Queue cannot be full and empty at once
	assert property (@(posedge clk) disable iff (!arst_n) !(fifo_st.full && fifo_st.empty))
		else $error("request queue full and empty together");

	// Back end never takes from an empty queue
	assert property (@(posedge clk) disable iff (!arst_n) bk_st.pop |-> !fifo_st.empty)
		else $error("pop from empty request queue");

	// A pop starts work on the next cycle
	assert property (@(posedge clk) disable iff (!arst_n) bk_st.pop |=> bk_st.busy)
		else $error("back end idle after pop");
`endif

endmodule
